/* hw/rtl/shdf_pkg.sv */
// ----------------------------------------------------------------------------
// shdf_pkg
// Sizes, types and constants for the spike history decay feature block.
// ----------------------------------------------------------------------------
package shdf_pkg;

  localparam int CHANNELS   = 8;
  localparam int HISTORY    = 4;
  localparam int ENTRIES    = CHANNELS * HISTORY;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SLOT_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int ENT_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TALLY_W    = $clog2(HISTORY + 1);

  localparam int MASK_W     = 8;
  localparam int CH_OUT_W   = 3;
  localparam int SLOT_OUT_W = 2;
  localparam int WEIGHT_W   = 17;
  localparam int DECAY_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int COLUMN_W   = 32;
  localparam int PROD_W     = WEIGHT_W + DECAY_W + 1;

  localparam logic [DECAY_W-1:0]  DECAY_RESET = 16'd59299;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE  = 17'h10000;
  localparam logic [PROD_W-1:0]   ROUND_HALF  = PROD_W'(32768);

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [DECAY_W-1:0]  decay_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } shdf_state_t;

  typedef struct packed {
    logic                step;
    logic                load_out;
    logic                last;
    logic                spiked;
    logic                newest;
    logic [ENT_W-1:0]    ent;
    logic [CH_W-1:0]     chan;
    logic [SLOT_W-1:0]   slot;
    logic [COLUMN_W-1:0] column;
  } shdf_step_t;

endpackage

/* hw/rtl/shdf_if.sv */
// ----------------------------------------------------------------------------
// shdf_if
// Valid/ready channels for spike bins and feature results.
// ----------------------------------------------------------------------------
interface shdf_in_if import shdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] spike_mask;

  modport source (output valid, output spike_mask, input ready);
  modport sink   (input valid, input spike_mask, output ready);
endinterface

interface shdf_out_if import shdf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_OUT_W-1:0]   channel_index;
  logic [SLOT_OUT_W-1:0] history_slot;
  logic [WEIGHT_W-1:0]   feature_weight;
  logic [COLUMN_W-1:0]   column_index;
  logic                  last;

  modport source (output valid, output channel_index, output history_slot,
                  output feature_weight, output column_index, output last,
                  input ready);
  modport sink   (input valid, input channel_index, input history_slot,
                  input feature_weight, input column_index, input last,
                  output ready);
endinterface

/* hw/rtl/spike_history_decay_features.sv */
// After a bin is accepted, each result item is registered in the output item register
// as its weight is stepped; a new bin is taken only in ST_IDLE, after the last one.
// One weight per cycle passes through the single shared decay multiplier while the
// output register is free. Bins before warm-up are stepped alike and produce no items.
// Reset (rst_n low, synchronous): weights, tallies, warm-up and column cleared,
// decay factor back to 59299.
// ----------------------------------------------------------------------------
// spike_history_decay_features
// Per-channel spike history weights with recursive exponential decay.
// ----------------------------------------------------------------------------
module spike_history_decay_features import shdf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  shdf_in_if.sink     in_ch,
  shdf_out_if.source  out_ch,
  input  logic        cfg_we,
  input  decay_t      cfg_wdata
);

  shdf_step_t step;
  logic       out_free;

  shdf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_free (out_free),
    .step_o   (step)
  );

  shdf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_i    (step),
    .out_free  (out_free),
    .out_ch    (out_ch)
  );

endmodule

/* hw/rtl/shdf_decay_mul.sv */
// ----------------------------------------------------------------------------
// shdf_decay_mul
// Shared decay multiplier: w * r rounded back to Q1.16.
// ----------------------------------------------------------------------------
module shdf_decay_mul import shdf_pkg::*; (
  input  weight_t w_i,
  input  decay_t  factor_i,
  output weight_t w_o
);

  logic [PROD_W-1:0] prod;

  assign prod = PROD_W'(w_i) * PROD_W'(factor_i) + ROUND_HALF;
  assign w_o  = prod[FRAC_W +: WEIGHT_W];

endmodule

/* hw/rtl/shdf_ctrl.sv */
// ----------------------------------------------------------------------------
// shdf_ctrl
// Sequencer: takes a bin, walks every weight once, tracks warm-up and columns.
// ----------------------------------------------------------------------------
module shdf_ctrl import shdf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  shdf_in_if.sink       in_ch,
  input  logic          out_free,
  output shdf_step_t    step_o
);

  shdf_state_t          state_r, state_nxt;
  logic [CHANNELS-1:0]  spk_r;
  logic [CHANNELS-1:0]  in_spk;
  logic                 emit_r;
  logic                 warm_r;
  logic [ENT_W-1:0]     ent_r;
  logic [CH_W-1:0]      ch_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [COLUMN_W-1:0]  column_r;
  logic [TALLY_W-1:0]   tally_r [CHANNELS];

  logic accept;
  logic all_full;
  logic step;
  logic newest;
  logic final_w;

  assign in_spk  = CHANNELS'(in_ch.spike_mask);
  assign accept  = in_ch.valid && in_ch.ready;
  assign newest  = (slot_r == SLOT_W'(HISTORY - 1));
  assign final_w = newest && (ch_r == CH_W'(CHANNELS - 1));

  always_comb begin
    all_full = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      if (tally_r[c] != TALLY_W'(HISTORY)) all_full = 1'b0;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    step        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        step = out_free;
        if (out_free && final_w) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r   <= 1'b0;
      emit_r   <= 1'b0;
      column_r <= '0;
      ent_r    <= '0;
      ch_r     <= '0;
      slot_r   <= '0;
      for (int c = 0; c < CHANNELS; c++) tally_r[c] <= '0;
    end else if (accept) begin
      warm_r <= warm_r | all_full;
      emit_r <= warm_r | all_full;
      ent_r  <= '0;
      ch_r   <= '0;
      slot_r <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        if (in_spk[c] && (tally_r[c] != TALLY_W'(HISTORY)))
          tally_r[c] <= tally_r[c] + TALLY_W'(1);
      end
    end else if (step) begin
      if (!final_w) ent_r <= ent_r + ENT_W'(1);
      if (newest) begin
        slot_r <= '0;
        if (!final_w) ch_r <= ch_r + CH_W'(1);
      end else begin
        slot_r <= slot_r + SLOT_W'(1);
      end
      if (final_w && emit_r) column_r <= column_r + COLUMN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) spk_r <= in_spk;
  end

  always_comb begin
    step_o.step     = step;
    step_o.load_out = step && emit_r;
    step_o.last     = final_w;
    step_o.spiked   = spk_r[ch_r];
    step_o.newest   = newest;
    step_o.ent      = ent_r;
    step_o.chan     = ch_r;
    step_o.slot     = slot_r;
    step_o.column   = column_r;
  end

endmodule

/* hw/rtl/shdf_datapath.sv */
// ----------------------------------------------------------------------------
// shdf_datapath
// Weight store, decay register, shared multiplier and output item register.
// ----------------------------------------------------------------------------
module shdf_datapath import shdf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  decay_t        cfg_wdata,
  input  shdf_step_t    step_i,
  output logic          out_free,
  shdf_out_if.source    out_ch
);

  decay_t               decay_r;
  weight_t              weight_r [ENTRIES];
  logic [ENT_W-1:0]     rd_idx;
  weight_t              rd_w;
  weight_t              dec_w;
  weight_t              new_w;

  logic                  out_valid_r;
  logic [CH_OUT_W-1:0]   ch_out_r;
  logic [SLOT_OUT_W-1:0] slot_out_r;
  weight_t               weight_out_r;
  logic [COLUMN_W-1:0]   column_out_r;
  logic                  last_out_r;

  // spiked channel: slot k takes the decayed weight of slot k+1
  assign rd_idx = step_i.ent + ENT_W'(step_i.spiked && !step_i.newest);
  assign rd_w   = weight_r[rd_idx];

  shdf_decay_mul u_mul (
    .w_i      (rd_w),
    .factor_i (decay_r),
    .w_o      (dec_w)
  );

  assign new_w    = (step_i.spiked && step_i.newest) ? WEIGHT_ONE : dec_w;
  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n)      decay_r <= DECAY_RESET;
    else if (cfg_we) decay_r <= cfg_wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < ENTRIES; e++) weight_r[e] <= '0;
    end else if (step_i.step) begin
      weight_r[step_i.ent] <= new_w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n)               out_valid_r <= 1'b0;
    else if (step_i.load_out) out_valid_r <= 1'b1;
    else if (out_ch.ready)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step_i.load_out) begin
      ch_out_r     <= CH_OUT_W'(step_i.chan);
      slot_out_r   <= SLOT_OUT_W'(step_i.slot);
      weight_out_r <= new_w;
      column_out_r <= step_i.column;
      last_out_r   <= step_i.last;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.channel_index  = ch_out_r;
  assign out_ch.history_slot   = slot_out_r;
  assign out_ch.feature_weight = weight_out_r;
  assign out_ch.column_index   = column_out_r;
  assign out_ch.last           = last_out_r;

endmodule

/* sim/spike_history_decay_features_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spike_history_decay_features_tb
// Drives spike bins through the valid/ready channel, stalls both sides at
// random and checks every feature item against an in-bench model of the decay
// history. Covers warm-up, the decay extremes and dense and sparse spiking.
// ----------------------------------------------------------------------------
module spike_history_decay_features_tb;
  import shdf_pkg::*;

  localparam int DRAIN_CYCLES = ENTRIES + 8;
  localparam int RANDOM_BINS  = 480;
  localparam int PHASE_BINS   = 60;

  typedef logic [MASK_W-1:0] mask_t;

  typedef struct packed {
    logic [CH_OUT_W-1:0]   chan;
    logic [SLOT_OUT_W-1:0] slot;
    weight_t               weight;
    logic [COLUMN_W-1:0]   column;
    logic                  last;
  } feature_t;

  typedef enum logic [1:0] {
    CHECK_PREDICTED,
    CHECK_SILENT,
    CHECK_FLUSHED
  } row_check_t;

  typedef struct packed {
    logic       wr;
    decay_t     factor;
    mask_t      mask;
    row_check_t check;
  } bin_row_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  decay_t cfg_wdata;

  shdf_in_if  in_bus ();
  shdf_out_if out_bus ();

  spike_history_decay_features dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  weight_t             hist_w [CHANNELS][HISTORY];
  int unsigned         spike_tally [CHANNELS];
  bit                  warm;
  logic [COLUMN_W-1:0] column_ctr;
  decay_t              decay_now;

  feature_t feature_q [$];
  bin_row_t dir_rows [$];
  int       fault_count;
  bit       in_calm;
  bit       out_calm;
  int       out_hold;
  int       out_draw;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 8));
  endfunction

  function automatic weight_t decay_once(input weight_t v);
    logic [PROD_W-1:0] p;
    p = PROD_W'(v) * PROD_W'(decay_now) + ROUND_HALF;
    return weight_t'(p >> FRAC_W);
  endfunction

  // Returns 1 when the bin emits features.
  function automatic bit advance_history(input mask_t m);
    bit full;
    full = 1'b1;
    for (int c = 0; c < CHANNELS; c++)
      if (spike_tally[c] < HISTORY) full = 1'b0;
    if (full) warm = 1'b1;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int h = 0; h < HISTORY; h++)
        hist_w[c][h] = decay_once(hist_w[c][h]);
      if ((c < MASK_W) && m[c]) begin
        for (int h = 0; h + 1 < HISTORY; h++)
          hist_w[c][h] = hist_w[c][h + 1];
        hist_w[c][HISTORY - 1] = WEIGHT_ONE;
        if (spike_tally[c] < HISTORY) spike_tally[c]++;
      end
    end
    return warm;
  endfunction

  // With zero decay only the spike of this bin survives.
  function automatic void queue_features(input mask_t m, input bit flushed);
    feature_t f;
    for (int c = 0; c < CHANNELS; c++) begin
      for (int h = 0; h < HISTORY; h++) begin
        f.chan   = CH_OUT_W'(c);
        f.slot   = SLOT_OUT_W'(h);
        f.column = column_ctr;
        f.last   = (c == CHANNELS - 1) && (h == HISTORY - 1);
        if (flushed)
          f.weight = ((h == HISTORY - 1) && m[c]) ? WEIGHT_ONE : '0;
        else
          f.weight = hist_w[c][h];
        feature_q = {feature_q, f};
      end
    end
    column_ctr = column_ctr + COLUMN_W'(1);
  endfunction

  function automatic void add_row(input logic wr, input decay_t factor,
                                  input mask_t mask, input row_check_t check);
    bin_row_t r;
    r = '{wr, factor, mask, check};
    dir_rows = {dir_rows, r};
  endfunction

  function automatic mask_t draw_mask();
    case ($urandom_range(0, 4))
      0: return mask_t'($urandom);
      1: return mask_t'($urandom & $urandom & $urandom);
      2: return mask_t'($urandom | $urandom);
      3: return mask_t'(1 << $urandom_range(0, MASK_W - 1));
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  function automatic decay_t draw_decay();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return decay_t'(1);
      3: return DECAY_RESET;
      default: return decay_t'($urandom);
    endcase
  endfunction

  task automatic send_bin(input mask_t m);
    int gap;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.spike_mask <= m;
    do @(posedge clk); while (!(in_bus.valid && in_bus.ready));
  endtask

  // Hold the input off and let the block drain before the write.
  task automatic set_decay(input decay_t f);
    in_bus.valid <= 1'b0;
    while (feature_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_we    <= 1'b0;
    decay_now = f;
  endtask

  task automatic run_bin(input mask_t m, input row_check_t check);
    bit emits;
    send_bin(m);
    emits = advance_history(m);
    case (check)
      CHECK_SILENT:  ;
      CHECK_FLUSHED: queue_features(m, 1'b1);
      default:       if (emits) queue_features(m, 1'b0);
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_hold      <= 0;
    end else if (out_hold > 0) begin
      out_hold      <= out_hold - 1;
      out_bus.ready <= (out_hold == 1);
    end else if (out_bus.valid && out_bus.ready) begin
      if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
      out_draw = draw_gap(out_calm);
      out_hold      <= out_draw;
      out_bus.ready <= (out_draw == 0);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : feature_check
    feature_t got;
    feature_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = '{out_bus.channel_index, out_bus.history_slot, out_bus.feature_weight,
              out_bus.column_index, out_bus.last};
      if (feature_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected item ch %0d slot %0d w %0d col %0d last %0b",
                   got.chan, got.slot, got.weight, got.column, got.last);
      end else begin
        want = feature_q.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch exp ch %0d slot %0d w %0d col %0d last %0b",
                     want.chan, want.slot, want.weight, want.column, want.last);
            $display("         got ch %0d slot %0d w %0d col %0d last %0b",
                     got.chan, got.slot, got.weight, got.column, got.last);
          end
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.spike_mask = '0;
    in_calm           = 1'b0;
    decay_now         = DECAY_RESET;
    warm              = 1'b0;
    column_ctr        = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      spike_tally[c] = 0;
      for (int h = 0; h < HISTORY; h++) hist_w[c][h] = '0;
    end

    // warm-up: nothing comes out until every channel held a full history
    add_row(1'b0, 16'd0,       8'h00, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'h01, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'h80, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'hff, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'hff, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'hff, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'hff, CHECK_SILENT);
    add_row(1'b0, 16'd0,       8'h00, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'haa, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'h55, CHECK_PREDICTED);
    add_row(1'b1, 16'd0,       8'hff, CHECK_FLUSHED);
    add_row(1'b0, 16'd0,       8'h00, CHECK_FLUSHED);
    add_row(1'b0, 16'd0,       8'h5a, CHECK_FLUSHED);
    add_row(1'b1, 16'hffff,    8'hff, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'h00, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'h00, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'h0f, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'hf0, CHECK_PREDICTED);
    add_row(1'b1, 16'd1,       8'hff, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'h00, CHECK_PREDICTED);
    add_row(1'b1, 16'h8000,    8'h3c, CHECK_PREDICTED);
    add_row(1'b1, DECAY_RESET, 8'hff, CHECK_PREDICTED);
    add_row(1'b0, 16'd0,       8'h00, CHECK_PREDICTED);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].wr) set_decay(dir_rows[i].factor);
      run_bin(dir_rows[i].mask, dir_rows[i].check);
    end

    for (int n = 0; n < RANDOM_BINS; n++) begin
      if (n % PHASE_BINS == 0) set_decay(draw_decay());
      run_bin(draw_mask(), CHECK_PREDICTED);
    end

    in_bus.valid <= 1'b0;
    while (feature_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (feature_q.size() != 0)
      $display("%0d feature items never arrived", feature_q.size());
    if ((fault_count == 0) && (feature_q.size() == 0))
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/shdf_pkg.sv
hw/rtl/shdf_if.sv
hw/rtl/shdf_decay_mul.sv
hw/rtl/shdf_ctrl.sv
hw/rtl/shdf_datapath.sv
hw/rtl/spike_history_decay_features.sv
sim/spike_history_decay_features_tb.sv
